[hdl/adcda_pkg.sv]
// Package for the ADC channel demux averager: widths, register map,
// controller states and the command/status structs. No dependencies.
`default_nettype none

package adcda_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  localparam int HDR_W = 8;
  localparam int NIBBLE_W = 4;
  localparam int CODE_W = 24;
  localparam int SAMPLE_W = 32;
  localparam int SUM_W = 40;
  localparam int COUNT_W = 8;
  localparam int FACTOR_W = 8;
  localparam int MASK_W = 4;
  localparam int OUT_IDX_W = 2;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_FACTOR = 1'b0;
  localparam logic REG_MASK = 1'b1;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = '0;
  localparam logic [MASK_W-1:0] MASK_RESET = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic div_start;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic raw;
    logic full;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

[hdl/adcda_div.sv]
// Serial restoring divider: 40-bit signed sum by an 8-bit factor, one
// quotient bit per cycle, truncation toward zero. Depends on adcda_pkg.
`default_nettype none

module adcda_div
  import adcda_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [SUM_W-1:0]    dividend,
  input  wire logic        [FACTOR_W-1:0] divisor,
  output logic                            busy,
  output logic signed [SAMPLE_W-1:0]      quotient
);

  logic [SUM_W-1:0]     quo;
  logic [FACTOR_W-1:0]  rem;
  logic [FACTOR_W-1:0]  dsr;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [FACTOR_W:0]    trial;
  logic [FACTOR_W:0]    diff;
  logic                 ge;
  logic [SUM_W-1:0]     mag;

  assign mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign trial = {rem, quo[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign ge    = trial >= {1'b0, dsr};
  assign quotient = neg ? -$signed(quo[SAMPLE_W-1:0]) : $signed(quo[SAMPLE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= mag;
      rem <= '0;
      dsr <= divisor;
      neg <= dividend[SUM_W-1];
      cnt <= DIV_CNT_W'(SUM_W - 1);
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? diff[FACTOR_W-1:0] : trial[FACTOR_W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

endmodule

`default_nettype wire

[hdl/adcda_ctrl.sv]
// Controller state machine: sequences capture, block update, division and
// result hand-off. Depends on adcda_pkg.
`default_nettype none

module adcda_ctrl
  import adcda_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.update = 1'b1;
        if (stat.hit && stat.raw) begin
          state_next = ST_EMIT;
        end else if (stat.hit && stat.full) begin
          cmd.div_start = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hdl/adcda_dp.sv]
// Datapath: input word capture, per-channel sums and counts, the serial
// divider and the output register. Depends on adcda_pkg and adcda_div.
`default_nettype none

module adcda_dp
  import adcda_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cmd_t                 cmd,
  output stat_t                     stat,
  input  wire logic [FACTOR_W-1:0]  average_factor,
  input  wire logic [MASK_W-1:0]    channel_enable_mask,
  input  wire logic [HDR_W-1:0]     header_byte,
  input  wire logic [CODE_W-1:0]    sample_code,
  input  wire logic                 frame_end,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [OUT_IDX_W-1:0]      channel_index,
  output logic signed [SAMPLE_W-1:0] mean_value
);

  logic [NIBBLE_W-1:0]        ch_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       last_q;

  logic signed [SUM_W-1:0]    sums [CHANNEL_COUNT];
  logic [COUNT_W-1:0]         counts [CHANNEL_COUNT];

  logic [CH_W-1:0]            idx;
  logic signed [SUM_W-1:0]    new_sum;
  logic [COUNT_W-1:0]         new_cnt;
  logic                       in_range;
  logic                       div_busy;
  logic signed [SAMPLE_W-1:0] div_q;
  logic                       out_free;

  assign idx      = ch_q[CH_W-1:0];
  assign new_sum  = sums[idx] + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
  assign new_cnt  = counts[idx] + 1'b1;
  assign in_range = ({1'b0, ch_q} < (NIBBLE_W+1)'(CHANNEL_COUNT))
                    && ({1'b0, ch_q} < (NIBBLE_W+1)'(MASK_W));
  assign out_free = !out_valid || out_ready;

  always_comb begin
    stat          = '0;
    stat.hit      = in_range && channel_enable_mask[ch_q[$clog2(MASK_W)-1:0]];
    stat.raw      = average_factor == '0;
    stat.full     = new_cnt >= average_factor;
    stat.div_busy = div_busy;
    stat.out_free = out_free;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_q     <= header_byte[HDR_W-1:HDR_W-NIBBLE_W];
      sample_q <= $signed({sample_code, 8'h00});
      last_q   <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        sums[i]   <= '0;
        counts[i] <= '0;
      end
    end else if (cmd.update) begin
      if (last_q) begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          sums[i]   <= '0;
          counts[i] <= '0;
        end
      end else if (stat.hit && !stat.raw) begin
        if (stat.full) begin
          sums[idx]   <= '0;
          counts[idx] <= '0;
        end else begin
          sums[idx]   <= new_sum;
          counts[idx] <= new_cnt;
        end
      end
    end
  end

  adcda_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (new_sum),
    .divisor  (average_factor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && out_free) begin
      channel_index <= ch_q[OUT_IDX_W-1:0];
      mean_value    <= stat.raw ? sample_q : div_q;
    end
  end

endmodule

`default_nettype wire

[hdl/adc_channel_demux_averager_core.sv]
// Top level of the ADC channel demux averager: configuration registers on
// the APB port, controller and datapath. Depends on adcda_pkg, adcda_ctrl, adcda_dp.
//
//   channel   handshake            payload
//   input     in_valid/in_ready    header_byte, sample_code, frame_end
//   output    out_valid/out_ready  channel_index, mean_value
//   config    APB write/read       average_factor (0x0), channel_enable_mask (0x4)
//
// A word that gives no result passes through ST_IDLE and ST_EVAL, and one with a raw
// passthrough result also through ST_EMIT. A word that completes a block goes through
// ST_IDLE, ST_EVAL, ST_DIV and ST_EMIT; in ST_DIV the serial divider produces one of
// 40 quotient bits per cycle. Reset clears all sums, counts and the output valid flag.
// A result waiting in the output register stalls only the next word that has a result.
`default_nettype none

module adc_channel_demux_averager_core
  import adcda_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [HDR_W-1:0]      header_byte,
  input  wire logic [CODE_W-1:0]     sample_code,
  input  wire logic                  frame_end,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_IDX_W-1:0]       channel_index,
  output logic signed [SAMPLE_W-1:0] mean_value,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready
);

  logic [FACTOR_W-1:0] average_factor;
  logic [MASK_W-1:0]   channel_enable_mask;
  cmd_t                cmd;
  stat_t               stat;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_factor      <= FACTOR_RESET;
      channel_enable_mask <= MASK_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_FACTOR: average_factor      <= pwdata[FACTOR_W-1:0];
        REG_MASK:   channel_enable_mask <= pwdata[MASK_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FACTOR: prdata = {{(PDATA_W-FACTOR_W){1'b0}}, average_factor};
      REG_MASK:   prdata = {{(PDATA_W-MASK_W){1'b0}}, channel_enable_mask};
      default:    prdata = '0;
    endcase
  end

  adcda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  adcda_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .stat                (stat),
    .average_factor      (average_factor),
    .channel_enable_mask (channel_enable_mask),
    .header_byte         (header_byte),
    .sample_code         (sample_code),
    .frame_end           (frame_end),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .channel_index       (channel_index),
    .mean_value          (mean_value)
  );

endmodule

`default_nettype wire

[hdl/adcda_checker.sv]
// Port-level checker for the ADC channel demux averager and its bind to
// the top level. Depends on adcda_pkg and adc_channel_demux_averager_core.
`default_nettype none

module adcda_checker
  import adcda_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic [HDR_W-1:0]      header_byte,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [OUT_IDX_W-1:0]  channel_index,
  input wire logic [SAMPLE_W-1:0]   mean_value,
  input wire logic                  pready
);

  logic bad_channel;

  assign bad_channel = {1'b0, header_byte[HDR_W-1:HDR_W-NIBBLE_W]}
                       >= (NIBBLE_W+1)'(CHANNEL_COUNT);

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mean_value) && $stable(channel_index))
    else $error("result word changed while stalled");

  // The block works on one input word at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while the previous word was in progress");

  // A word for a channel that does not exist never produces a result.
  a_bad_channel_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && bad_channel |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result produced for an out-of-range channel");

  a_pready_high: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind adc_channel_demux_averager_core adcda_checker u_adcda_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .header_byte   (header_byte),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .channel_index (channel_index),
  .mean_value    (mean_value),
  .pready        (pready)
);

`default_nettype wire

[test/adcda_mean_checker.sv]
// Scoreboard for the ADC channel demux averager: follows the APB register
// writes, checks the reads, predicts every mean word from the accepted ADC
// words and compares it with the output channel. Depends on adcda_pkg.
module adcda_mean_checker
  import adcda_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [HDR_W-1:0]      header_byte,
  input  wire logic [CODE_W-1:0]     sample_code,
  input  wire logic                  frame_end,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [OUT_IDX_W-1:0]  channel_index,
  input  wire logic [SAMPLE_W-1:0]   mean_value,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [PDATA_W-1:0]    pwdata,
  input  wire logic [PDATA_W-1:0]    prdata,
  input  wire logic                  pready,
  output int                         words_pending,
  output int                         fail_count
);

  localparam logic [PADDR_W-1:0] ADDR_FACTOR = {REG_FACTOR, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_MASK = {REG_MASK, 2'b00};

  typedef struct packed {
    logic [OUT_IDX_W-1:0] chan;
    logic [SAMPLE_W-1:0]  mean;
  } mean_word_t;

  mean_word_t              means_due[$];
  logic [FACTOR_W-1:0]     factor_q = FACTOR_RESET;
  logic [MASK_W-1:0]       mask_q = MASK_RESET;
  logic signed [SUM_W-1:0] block_sum [CHANNEL_COUNT];
  logic [COUNT_W-1:0]      block_count [CHANNEL_COUNT];
  int                      err_count = 0;

  function automatic void clear_blocks();
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      block_sum[c] = '0;
      block_count[c] = '0;
    end
  endfunction

  function automatic void average_word(input logic [HDR_W-1:0] hdr,
                                       input logic [CODE_W-1:0] code,
                                       input logic last);
    logic [NIBBLE_W-1:0]        chan;
    logic signed [SAMPLE_W-1:0] smp;
    logic signed [SUM_W-1:0]    quot;
    mean_word_t                 w;
    chan = hdr[HDR_W-1 -: NIBBLE_W];
    smp = {code, {(SAMPLE_W-CODE_W){1'b0}}};
    if (chan < CHANNEL_COUNT && mask_q[chan]) begin
      w.chan = chan[OUT_IDX_W-1:0];
      if (factor_q == '0) begin
        w.mean = smp;
        means_due.push_back(w);
      end else begin
        block_sum[chan] = block_sum[chan] + smp;
        block_count[chan] = block_count[chan] + 1'b1;
        if (block_count[chan] >= factor_q) begin
          quot = block_sum[chan] / $signed({1'b0, factor_q});
          w.mean = quot[SAMPLE_W-1:0];
          means_due.push_back(w);
          block_sum[chan] = '0;
          block_count[chan] = '0;
        end
      end
    end
    if (last) clear_blocks();
  endfunction

  initial clear_blocks();

  always @(posedge clk) begin : watch
    mean_word_t          exp_w;
    logic [PDATA_W-1:0]  exp_rd;
    if (rst) begin
      factor_q = FACTOR_RESET;
      mask_q = MASK_RESET;
      clear_blocks();
      means_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (means_due.size() == 0) begin
          err_count++;
          $error("unexpected word: channel_index %0d, mean_value %0d",
                 channel_index, $signed(mean_value));
        end else begin
          exp_w = means_due.pop_front();
          if (channel_index !== exp_w.chan) begin
            err_count++;
            $error("channel_index: expected %0d, actual %0d", exp_w.chan, channel_index);
          end
          if (mean_value !== exp_w.mean) begin
            err_count++;
            $error("mean_value: expected %0d, actual %0d",
                   $signed(exp_w.mean), $signed(mean_value));
          end
        end
      end
      if (in_valid && in_ready) average_word(header_byte, sample_code, frame_end);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == ADDR_FACTOR) factor_q = pwdata[FACTOR_W-1:0];
          else if (paddr == ADDR_MASK) mask_q = pwdata[MASK_W-1:0];
        end else begin
          exp_rd = (paddr == ADDR_FACTOR) ? PDATA_W'(factor_q) : PDATA_W'(mask_q);
          if (prdata !== exp_rd) begin
            err_count++;
            $error("prdata: expected %0d, actual %0d", exp_rd, prdata);
          end
        end
      end
    end
    words_pending <= means_due.size();
    fail_count <= err_count;
  end

endmodule

[test/adc_channel_demux_averager_core_tb.sv]
// Testbench top for adc_channel_demux_averager_core: drives ADC words and
// APB register settings and gives the verdict. Depends on adcda_pkg, the
// core and adcda_mean_checker.
module adc_channel_demux_averager_core_tb;
  import adcda_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [PADDR_W-1:0] ADDR_FACTOR = {REG_FACTOR, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_MASK = {REG_MASK, 2'b00};

  typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SHUT} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [HDR_W-1:0]      header_byte = '0;
  logic [CODE_W-1:0]     sample_code = '0;
  logic                  frame_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_IDX_W-1:0]  channel_index;
  logic [SAMPLE_W-1:0]   mean_value;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  int                    words_pending;
  int                    fail_count;
  int                    cycle_count = 0;
  int                    burst_left = 0;
  logic                  hold_off_req = 1'b0;

  adc_channel_demux_averager_core u_dut (.*);

  adcda_mean_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("adc_channel_demux_averager_core_tb NOT OK");
      $finish;
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int       span;
    bit       held;
    held = 1'b0;
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = rx_mode_t'($urandom_range(0, 3));
      span = (mode == RX_SHUT) ? $urandom_range(1, 12) : $urandom_range(1, 40);
      repeat (span) begin
        case (mode)
          RX_OPEN: out_ready <= 1'b1;
          RX_COIN: out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [HDR_W-1:0] hdr, input logic [CODE_W-1:0] code,
                           input logic last);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    header_byte <= hdr;
    sample_code <= code;
    frame_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register and reads it back in the following transfer.
  task automatic program_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [FACTOR_W-1:0] factor, input logic [MASK_W-1:0] mask);
    settle();
    program_reg(ADDR_FACTOR, PDATA_W'(factor));
    program_reg(ADDR_MASK, PDATA_W'(mask));
  endtask

  // Mostly words for channels 0..3, some for absent channels, and codes that
  // lean toward the extremes of the signed sample range and toward zero.
  task automatic random_phase(input int count, input int end_odds);
    logic [NIBBLE_W-1:0] chan;
    logic [CODE_W-1:0]   code;
    logic                last;
    repeat (count) begin
      chan = ($urandom_range(0, 9) == 0) ? NIBBLE_W'($urandom_range(CHANNEL_COUNT, 15))
                                         : NIBBLE_W'($urandom_range(0, CHANNEL_COUNT - 1));
      case ($urandom_range(0, 7))
        0: code = {1'b0, {(CODE_W-1){1'b1}}};
        1: code = {1'b1, {(CODE_W-1){1'b0}}};
        2: code = CODE_W'($urandom_range(0, 3)) - CODE_W'($urandom_range(0, 3));
        default: code = CODE_W'($urandom);
      endcase
      last = (end_odds != 0) && ($urandom_range(1, end_odds) == 1);
      send_word({chan, NIBBLE_W'($urandom)}, code, last);
    end
  endtask

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Raw passthrough with the reset settings, absent channels and frame end.
    send_word(8'h00, 24'h000000, 1'b0);
    send_word(8'h1F, 24'hFFFFFF, 1'b0);
    send_word(8'h20, 24'h800000, 1'b0);
    send_word(8'h35, 24'h7FFFFF, 1'b0);
    send_word(8'h40, 24'h123456, 1'b0);
    send_word(8'hF0, 24'hABCDEF, 1'b1);

    // Pairs on channels 0 and 2, channel 1 disabled, frame end on a dropped word.
    set_config(8'd2, 4'b0101);
    send_word(8'h00, 24'h7FFFFF, 1'b0);
    send_word(8'h00, 24'h7FFFFF, 1'b0);
    send_word(8'h10, 24'h000001, 1'b0);
    send_word(8'h20, 24'h800000, 1'b0);
    send_word(8'h20, 24'h800000, 1'b0);
    send_word(8'h00, 24'h000100, 1'b0);
    send_word(8'hA0, 24'h000000, 1'b1);
    send_word(8'h00, 24'h000200, 1'b0);
    send_word(8'h00, 24'h000300, 1'b0);

    // Division by three truncates toward zero on both signs.
    set_config(8'd3, 4'b1111);
    send_word(8'h30, 24'hFFFFFF, 1'b0);
    send_word(8'h30, 24'h000000, 1'b0);
    send_word(8'h30, 24'h000000, 1'b0);
    send_word(8'h30, 24'h000001, 1'b0);
    send_word(8'h30, 24'h000000, 1'b0);
    send_word(8'h30, 24'h000000, 1'b1);

    set_config(8'd1, 4'b1111);
    random_phase(50, 16);

    set_config(8'd0, 4'b1111);
    hold_off_req <= 1'b1;
    random_phase(70, 16);

    // Long blocks left open, then a lower factor flushes those of channels 0 and 3.
    set_config(8'd255, 4'b1111);
    random_phase(50, 0);
    set_config(8'd4, 4'b1001);
    random_phase(60, 0);

    set_config(8'd2, 4'b0000);
    random_phase(20, 8);

    set_config(8'd5, MASK_W'($urandom));
    random_phase(60, 12);

    set_config(FACTOR_W'($urandom_range(1, 8)), MASK_W'($urandom_range(1, 15)));
    random_phase(70, 12);

    settle();
    if (fail_count == 0) begin
      $display("adc_channel_demux_averager_core_tb OK");
    end else begin
      $display("adc_channel_demux_averager_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[adc_channel_demux_averager_core.f]
hdl/adcda_pkg.sv
hdl/adcda_div.sv
hdl/adcda_ctrl.sv
hdl/adcda_dp.sv
hdl/adc_channel_demux_averager_core.sv
hdl/adcda_checker.sv
test/adcda_mean_checker.sv
test/adc_channel_demux_averager_core_tb.sv
